// File: sv/mi3_pkg.sv
// Shared widths, word types and the saturation function of the 3x3 matrix inverse unit.
package mi3_pkg;

	localparam int W    = 32;   // element width
	localparam int PW   = 64;   // width of one 32 by 32 product
	localparam int CW   = 65;   // signed cofactor width
	localparam int CMW  = 64;   // cofactor magnitude width
	localparam int DW   = 97;   // signed determinant width
	localparam int DMW  = 96;   // determinant magnitude width
	localparam int QB   = 33;   // quotient bits resolved by the divider
	localparam int SATW = 128;  // magnitude width seen by the saturation function
	localparam int NE   = 9;    // elements in one matrix

	typedef logic signed [W-1:0] elem_t;
	typedef elem_t [NE-1:0] mat_t;

	// Word passed from the front end through the queue to the back end.
	// Cofactor magnitudes and signs are already in result order (transposed).
	typedef struct packed {
		mat_t                     m;
		logic [NE-1:0][CMW-1:0]   cmag;
		logic [NE-1:0]            rneg;
		logic [DMW-1:0]           dmag;
		logic                     sing;
		elem_t                    det;
	} q_t;

	// Fields that travel alongside the divider stages.
	typedef struct packed {
		mat_t           m;
		logic [DMW-1:0] dmag;
		logic           sing;
		elem_t          det;
	} bk_t;

	// Clamp a sign and magnitude to the signed 32-bit range.
	function automatic elem_t sat_fn(input logic neg, input logic [SATW-1:0] mag);
		elem_t r;
		if (neg) begin
			if (mag > SATW'(33'h1_0000_0000 >> 1))
				r = elem_t'({1'b1, {(W-1){1'b0}}});
			else
				r = elem_t'(32'd0 - mag[W-1:0]);
		end else begin
			if (mag > SATW'({1'b0, {(W-1){1'b1}}}))
				r = elem_t'({1'b0, {(W-1){1'b1}}});
			else
				r = elem_t'(mag[W-1:0]);
		end
		return r;
	endfunction

endpackage

// File: sv/mi3_front.sv
// Front end: takes matrices, forms cofactors and determinant, and classifies each one.
module mi3_front #(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_vld,
	input  mi3_pkg::mat_t in_m,
	output logic         out_vld,
	output mi3_pkg::q_t  out_word
);
	import mi3_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	mat_t m_s1, m_s2, m_s3, m_s4, m_s5, m_s6, m_s7;

	logic signed [PW-1:0] pa_s2 [NE];
	logic signed [PW-1:0] pb_s2 [NE];
	logic signed [CW-1:0] cof_s3 [NE];
	logic signed [CW-1:0] cof_s4 [NE];
	logic signed [CW-1:0] cof_s5 [NE];
	logic signed [CW-1:0] cof_s6 [NE];
	logic signed [CW-1:0] ph_s4 [3];
	logic signed [CW-1:0] pl_s4 [3];
	logic signed [DW-1:0] pk_s5 [3];
	logic signed [DW-1:0] det_s6;
	logic [CMW-1:0] cmag_s7 [NE];
	logic [NE-1:0]  cneg_s7;
	logic [DMW-1:0] dmag_s7;
	logic           dneg_s7;
	logic           sing_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		m_s1   <= in_m;
		m_s2   <= m_s1;
		m_s3   <= m_s2;
		m_s4   <= m_s3;
		m_s5   <= m_s4;
		m_s6   <= m_s5;
		m_s7   <= m_s6;
		cof_s4 <= cof_s3;
		cof_s5 <= cof_s4;
		cof_s6 <= cof_s5;
	end

	// Minor products and signed cofactors, cofactor (q,k) at index q*3+k.
	for (genvar q = 0; q < 3; q++) begin : g_row
		for (genvar k = 0; k < 3; k++) begin : g_col
			localparam int R1 = (q == 0) ? 1 : 0;
			localparam int R2 = (q == 2) ? 1 : 2;
			localparam int C1 = (k == 0) ? 1 : 0;
			localparam int C2 = (k == 2) ? 1 : 2;
			localparam int IX = q * 3 + k;
			logic signed [CW-1:0] mn;

			always_ff @(posedge clk) begin
				pa_s2[IX] <= $signed(m_s1[R1*3+C1]) * $signed(m_s1[R2*3+C2]);
				pb_s2[IX] <= $signed(m_s1[R1*3+C2]) * $signed(m_s1[R2*3+C1]);
			end

			assign mn = $signed({pa_s2[IX][PW-1], pa_s2[IX]})
			          - $signed({pb_s2[IX][PW-1], pb_s2[IX]});

			always_ff @(posedge clk) begin
				if (((q + k) % 2) == 1)
					cof_s3[IX] <= -mn;
				else
					cof_s3[IX] <= mn;
			end
		end
	end

	// Determinant along row 0, each 32 by 65 product split into two halves.
	for (genvar k = 0; k < 3; k++) begin : g_det
		logic signed [DW-1:0] phx, plx;

		always_ff @(posedge clk) begin
			ph_s4[k] <= $signed(m_s3[k]) * $signed(cof_s3[k][CW-1:W]);
			pl_s4[k] <= $signed(m_s3[k]) * $signed({1'b0, cof_s3[k][W-1:0]});
		end

		assign phx = $signed({{(DW-CW){ph_s4[k][CW-1]}}, ph_s4[k]});
		assign plx = $signed({{(DW-CW){pl_s4[k][CW-1]}}, pl_s4[k]});

		always_ff @(posedge clk) begin
			pk_s5[k] <= (phx <<< W) + plx;
		end
	end

	always_ff @(posedge clk) begin
		det_s6 <= pk_s5[0] + pk_s5[1] + pk_s5[2];
	end

	// Classification: singular test, signs and magnitudes.
	logic signed [DW-1:0] dabs;
	assign dabs = det_s6[DW-1] ? -det_s6 : det_s6;

	always_ff @(posedge clk) begin
		sing_s7 <= (det_s6 == '0);
		dneg_s7 <= det_s6[DW-1];
		dmag_s7 <= dabs[DMW-1:0];
	end

	for (genvar i = 0; i < NE; i++) begin : g_abs
		logic signed [CW-1:0] cabs;
		assign cabs = cof_s6[i][CW-1] ? -cof_s6[i] : cof_s6[i];
		always_ff @(posedge clk) begin
			cneg_s7[i] <= cof_s6[i][CW-1];
			cmag_s7[i] <= cabs[CMW-1:0];
		end
	end

	// Rounded determinant and the queue word.
	logic [DMW:0] rsum, rdet;
	assign rsum = {1'b0, dmag_s7} + ((DMW+1)'(1) << (2 * FRAC_BITS - 1));
	assign rdet = rsum >> (2 * FRAC_BITS);

	always_comb begin
		out_word.m    = m_s7;
		out_word.dmag = dmag_s7;
		out_word.sing = sing_s7;
		out_word.det  = sat_fn(dneg_s7, SATW'(rdet));
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				out_word.cmag[i*3+j] = cmag_s7[j*3+i];
				out_word.rneg[i*3+j] = cneg_s7[j*3+i] ^ dneg_s7;
			end
		end
	end

	assign out_vld = vld_s7;

endmodule

// File: sv/mi3_queue.sv
// Two-word queue between the front end and the back end.
module mi3_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  mi3_pkg::q_t din,
	output logic        pop,
	output mi3_pkg::q_t dout,
	output logic        full
);
	import mi3_pkg::*;

	q_t         mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	// The back end takes a word in every cycle one is waiting.
	assign pop  = (cnt_q != 2'd0);
	assign dout = mem_q[rd_ptr_q];
	assign full = (cnt_q == 2'd2);

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// File: sv/mi3_div.sv
// Pipelined restoring divider: one quotient bit per stage, then rounding and saturation.
module mi3_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic                     clk,
	input  logic [mi3_pkg::CMW-1:0]  cmag,
	input  logic                     neg,
	input  logic [mi3_pkg::DMW-1:0]  d_in,
	input  logic [mi3_pkg::DMW-1:0]  d_pipe [mi3_pkg::QB+1],
	output mi3_pkg::elem_t           res
);
	import mi3_pkg::*;

	localparam int NW  = CMW + 2 * FRAC_BITS;
	localparam int RW  = NW - QB;
	localparam int CPW = (RW > DMW) ? RW : DMW;

	logic [NW-1:0]  num;
	logic [CPW-1:0] rem0;
	logic [DMW-1:0] rem_s [QB+1];
	logic [QB-1:0]  low_s [QB+1];
	logic [QB-1:0]  q_s   [QB+1];
	logic           ovf_s [QB+1];
	logic           neg_s [QB+1];

	assign num  = {cmag, {(2 * FRAC_BITS){1'b0}}};
	assign rem0 = CPW'(num[NW-1:QB]);

	// A quotient of 2^QB or more saturates whatever its sign.
	always_ff @(posedge clk) begin
		rem_s[0] <= rem0[DMW-1:0];
		low_s[0] <= num[QB-1:0];
		q_s[0]   <= '0;
		ovf_s[0] <= (rem0 >= CPW'(d_in));
		neg_s[0] <= neg;
	end

	for (genvar k = 0; k < QB; k++) begin : g_step
		logic [DMW:0] t, diff;
		logic         ge;
		assign t    = {rem_s[k], low_s[k][QB-1]};
		assign ge   = (t >= {1'b0, d_pipe[k]});
		assign diff = t - {1'b0, d_pipe[k]};
		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? diff[DMW-1:0] : t[DMW-1:0];
			low_s[k+1] <= {low_s[k][QB-2:0], 1'b0};
			q_s[k+1]   <= {q_s[k][QB-2:0], ge};
			ovf_s[k+1] <= ovf_s[k];
			neg_s[k+1] <= neg_s[k];
		end
	end

	// Round half up on the remainder, then clamp.
	logic          rnd;
	logic [QB:0]   qf;
	logic [SATW-1:0] mag;
	assign rnd = ({rem_s[QB], 1'b0} >= {1'b0, d_pipe[QB]});
	assign qf  = {1'b0, q_s[QB]} + {{QB{1'b0}}, rnd};
	assign mag = ovf_s[QB] ? {SATW{1'b1}} : SATW'(qf);

	always_ff @(posedge clk) begin
		res <= sat_fn(neg_s[QB], mag);
	end

endmodule

// File: sv/mi3_back.sv
// Back end: nine divider pipelines, singular pass-through and the identity check.
module mi3_back #(
	parameter int FRAC_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_vld,
	input  mi3_pkg::q_t    in_word,
	input  logic [15:0]    tol,
	output logic           out_vld,
	output mi3_pkg::mat_t  out_r,
	output mi3_pkg::elem_t out_det,
	output logic           out_sing,
	output logic           out_ident
);
	import mi3_pkg::*;

	localparam int LD = QB + 2;

	bk_t            line_s [LD];
	logic [LD-1:0]  vld_s;
	logic [DMW-1:0] d_pipe [QB+1];
	elem_t          qres [NE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else
			vld_s <= {vld_s[LD-2:0], in_vld};
	end

	always_ff @(posedge clk) begin
		line_s[0].m    <= in_word.m;
		line_s[0].dmag <= in_word.dmag;
		line_s[0].sing <= in_word.sing;
		line_s[0].det  <= in_word.det;
		for (int k = 1; k < LD; k++)
			line_s[k] <= line_s[k-1];
	end

	always_comb begin
		for (int k = 0; k <= QB; k++)
			d_pipe[k] = line_s[k].dmag;
	end

	for (genvar i = 0; i < NE; i++) begin : g_div
		mi3_div #(.FRAC_BITS(FRAC_BITS)) u_div (
			.clk    (clk),
			.cmag   (in_word.cmag[i]),
			.neg    (in_word.rneg[i]),
			.d_in   (in_word.dmag),
			.d_pipe (d_pipe),
			.res    (qres[i])
		);
	end

	// Result selection and identity test against the tolerance.
	mat_t           rsel;
	logic [NE-1:0]  ok;
	always_comb begin
		for (int i = 0; i < NE; i++) begin
			logic signed [W+1:0] one, diff, dabs;
			rsel[i] = line_s[LD-1].sing ? line_s[LD-1].m[i] : qres[i];
			one     = ((i % 4) == 0) ? ((W+2)'(1) <<< FRAC_BITS) : '0;
			diff    = $signed({rsel[i][W-1], rsel[i][W-1], rsel[i]}) - one;
			dabs    = diff[W+1] ? -diff : diff;
			ok[i]   = (dabs < $signed({{(W+2-16){1'b0}}, tol}));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld <= 1'b0;
		else
			out_vld <= vld_s[LD-1];
	end

	always_ff @(posedge clk) begin
		out_r     <= rsel;
		out_det   <= line_s[LD-1].sing ? '0 : line_s[LD-1].det;
		out_sing  <= line_s[LD-1].sing;
		out_ident <= &ok;
	end

endmodule

// File: sv/matrix3_inverse_unit.sv
// Top level of the 3x3 fixed-point matrix inverse unit.
// The pipeline depth does not depend on FRAC_BITS.
// Throughput: one matrix per clock cycle while busy is low; the divider pipeline is the longest part.
// The receiver cannot stall: done is high for exactly one cycle per result word.
// Reset (arst_n low, asynchronous) empties all pipelines and the queue and sets the
// identity tolerance to 66; no clearing pass is needed.
module matrix3_inverse_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  mi3_pkg::elem_t        m00, m01, m02,
	input  mi3_pkg::elem_t        m10, m11, m12,
	input  mi3_pkg::elem_t        m20, m21, m22,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [15:0]           cfg_data,
	output logic                  done,
	output mi3_pkg::elem_t        r00, r01, r02,
	output mi3_pkg::elem_t        r10, r11, r12,
	output mi3_pkg::elem_t        r20, r21, r22,
	output mi3_pkg::elem_t        determinant,
	output logic                  singular,
	output logic                  is_identity
);
	import mi3_pkg::*;

	localparam logic [15:0] TOL_RESET = 16'd66;

	// Identity tolerance register. Writes are always taken.
	logic [15:0] tol_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tol_q <= TOL_RESET;
		else if (cfg_valid && cfg_ready)
			tol_q <= cfg_data;
	end

	// The front end takes a word whenever start is high and the unit is not busy.
	logic  accept;
	mat_t  in_m;
	assign accept = start && !busy;
	assign in_m   = {m22, m21, m20, m12, m11, m10, m02, m01, m00};

	logic f_vld;
	q_t   f_word;

	mi3_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (accept),
		.in_m     (in_m),
		.out_vld  (f_vld),
		.out_word (f_word)
	);

	// The queue decouples the two halves. The back end drains one word in
	// every cycle that one waits, so in practice it holds at most one word.
	logic q_pop, q_full;
	q_t   q_word;

	mi3_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_vld),
		.din    (f_word),
		.pop    (q_pop),
		.dout   (q_word),
		.full   (q_full)
	);

	assign busy = q_full;

	// Back end: division, singular pass-through and identity check.
	mat_t r_m;

	mi3_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (q_pop),
		.in_word   (q_word),
		.tol       (tol_q),
		.out_vld   (done),
		.out_r     (r_m),
		.out_det   (determinant),
		.out_sing  (singular),
		.out_ident (is_identity)
	);

	assign r00 = r_m[0];
	assign r01 = r_m[1];
	assign r02 = r_m[2];
	assign r10 = r_m[3];
	assign r11 = r_m[4];
	assign r12 = r_m[5];
	assign r20 = r_m[6];
	assign r21 = r_m[7];
	assign r22 = r_m[8];

endmodule

// File: sim/tb.sv
// Self-checking testbench for the 3x3 fixed-point matrix inverse unit.
`timescale 1ns / 100ps

module tb;
	import mi3_pkg::*;

	localparam int PIPE_LAT = 44;

	// One result word as it leaves the block.
	typedef struct {
		mat_t  r;
		elem_t det;
		logic  sing;
		logic  ident;
	} inv_word_t;

	// Scoreboard: predicts the inverse of each accepted matrix and holds the
	// predictions in acceptance order until the matching result word comes back.
	class inverse_board;
		inv_word_t    pending[$];
		logic [15:0]  tol = 16'd66;
		int           errors = 0;
		int           words = 0;
		int           singulars = 0;
		int           identities = 0;

		// Clamp a sign and magnitude to the signed 32-bit range.
		function elem_t clamp32(logic neg, logic [127:0] mag);
			if (neg)
				return (mag > 128'h8000_0000) ? 32'sh8000_0000 : elem_t'(-mag[31:0]);
			return (mag > 128'h7fff_ffff) ? 32'sh7fff_ffff : elem_t'(mag[31:0]);
		endfunction

		function logic near_identity(mat_t r);
			longint d;
			for (int i = 0; i < NE; i++) begin
				d = longint'(r[i]) - ((i % 4 == 0) ? 64'sd65536 : 64'sd0);
				if (d < 0)
					d = -d;
				if (d >= longint'(tol))
					return 1'b0;
			end
			return 1'b1;
		endfunction

		// Exact adjugate and determinant in 128 bits, then rounded quotients.
		function inv_word_t invert(mat_t m);
			logic signed [127:0] a [NE];
			logic signed [127:0] cof [3][3];
			logic signed [127:0] det, minor_v;
			logic [127:0] dmag, cmag, num, quo, rem;
			logic dneg;
			int r1, r2, c1, c2;
			inv_word_t w;
			for (int i = 0; i < NE; i++)
				a[i] = 128'(m[i]);
			for (int q = 0; q < 3; q++)
				for (int k = 0; k < 3; k++) begin
					r1 = (q == 0) ? 1 : 0;
					r2 = (q == 2) ? 1 : 2;
					c1 = (k == 0) ? 1 : 0;
					c2 = (k == 2) ? 1 : 2;
					minor_v = a[r1*3+c1] * a[r2*3+c2] - a[r1*3+c2] * a[r2*3+c1];
					cof[q][k] = ((q + k) % 2 == 1) ? -minor_v : minor_v;
				end
			det = '0;
			for (int k = 0; k < 3; k++)
				det = det + a[k] * cof[0][k];
			if (det == 0) begin
				w.r = m;
				w.det = '0;
				w.sing = 1'b1;
			end else begin
				dneg = det < 0;
				dmag = dneg ? -det : det;
				for (int i = 0; i < 3; i++)
					for (int j = 0; j < 3; j++) begin
						cmag = (cof[j][i] < 0) ? -cof[j][i] : cof[j][i];
						num = cmag << 32;
						quo = num / dmag;
						rem = num % dmag;
						if ((rem << 1) >= dmag)
							quo = quo + 1;
						w.r[i*3+j] = clamp32((cof[j][i] < 0) != dneg, quo);
					end
				// The determinant carries 48 fraction bits; round it back to 16.
				w.det = clamp32(dneg, (dmag + 128'h8000_0000) >> 32);
				w.sing = 1'b0;
			end
			w.ident = near_identity(w.r);
			return w;
		endfunction

		function void note_matrix(mat_t m);
			pending.push_back(invert(m));
		endfunction

		function void check_word(inv_word_t got);
			inv_word_t want;
			words++;
			if (got.sing)
				singulars++;
			if (got.ident)
				identities++;
			if (pending.size() == 0) begin
				$error("result word arrived with no matrix outstanding");
				errors++;
				return;
			end
			want = pending.pop_front();
			for (int i = 0; i < NE; i++)
				if (got.r[i] !== want.r[i]) begin
					$error("r%0d%0d expected %0d actual %0d", i / 3, i % 3,
						want.r[i], got.r[i]);
					errors++;
				end
			if (got.det !== want.det) begin
				$error("determinant expected %0d actual %0d", want.det, got.det);
				errors++;
			end
			if (got.sing !== want.sing) begin
				$error("singular expected %0b actual %0b", want.sing, got.sing);
				errors++;
			end
			if (got.ident !== want.ident) begin
				$error("is_identity expected %0b actual %0b", want.ident, got.ident);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	elem_t       m00 = '0, m01 = '0, m02 = '0, m10 = '0, m11 = '0, m12 = '0;
	elem_t       m20 = '0, m21 = '0, m22 = '0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;
	logic        done;
	elem_t       r00, r01, r02, r10, r11, r12, r20, r21, r22, determinant;
	logic        singular, is_identity;

	inverse_board sb = new();
	int           sent = 0;
	bit           no_gaps = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	matrix3_inverse_unit u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
		.m20(m20), .m21(m21), .m22(m22),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.done(done),
		.r00(r00), .r01(r01), .r02(r02), .r10(r10), .r11(r11), .r12(r12),
		.r20(r20), .r21(r21), .r22(r22),
		.determinant(determinant), .singular(singular), .is_identity(is_identity)
	);

	// The receiver cannot hold results off, so every strobed word is taken at once.
	always @(posedge clk) begin
		inv_word_t w;
		if (done) begin
			w.r = '{r22, r21, r20, r12, r11, r10, r02, r01, r00};
			w.det = determinant;
			w.sing = singular;
			w.ident = is_identity;
			sb.check_word(w);
		end
	end

	// Mostly short gaps, now and then a long one, and none at all in burst stretches.
	function automatic int pick_gap();
		int p;
		if (no_gaps)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offer one matrix and hold it until the block takes it. The start line is
	// assigned only once per edge, so back-to-back words keep it high.
	task automatic send_matrix(mat_t m);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		{m22, m21, m20, m12, m11, m10, m02, m01, m00} <= m;
		do
			@(posedge clk);
		while (busy);
		sb.note_matrix(m);
		sent++;
	endtask

	// Drain everything outstanding, then let the pipeline settle fully.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 6) @(posedge clk);
	endtask

	task automatic write_tolerance(logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.tol = v;
	endtask

	function automatic elem_t rnd_range(int lim);
		return elem_t'($signed($urandom_range(0, 2 * lim)) - lim);
	endfunction

	function automatic elem_t pick_extreme();
		case ($urandom_range(0, 6))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return 32'sd0;
			3: return -32'sd1;
			4: return 32'sd1;
			5: return 32'sd65536;
			default: return -32'sd65536;
		endcase
	endfunction

	function automatic mat_t one_eye(elem_t s);
		mat_t m;
		m = '0;
		m[0] = s;
		m[4] = s;
		m[8] = s;
		return m;
	endfunction

	// Random matrices of several flavours: well conditioned, raw bit patterns,
	// singular by construction, near identity, tiny and extreme elements.
	function automatic mat_t random_matrix();
		mat_t m;
		int k;
		k = $urandom_range(0, 99);
		for (int i = 0; i < NE; i++)
			m[i] = rnd_range(4 << 16);
		if (k < 30) begin
			// well conditioned values within plus or minus four
		end else if (k < 45) begin
			for (int i = 0; i < NE; i++)
				m[i] = elem_t'($urandom());
		end else if (k < 60) begin
			// copy or zero a row, or make one row the sum of the others
			case ($urandom_range(0, 2))
				0: for (int j = 0; j < 3; j++) m[6+j] = m[j];
				1: for (int j = 0; j < 3; j++) m[3+j] = '0;
				default: for (int j = 0; j < 3; j++) m[j] = m[3+j] + m[6+j];
			endcase
		end else if (k < 75) begin
			m = one_eye(32'sd65536);
			for (int i = 0; i < NE; i++)
				m[i] = m[i] + rnd_range(($urandom_range(0, 1) == 1) ? 8 : 200);
		end else if (k < 88) begin
			for (int i = 0; i < NE; i++)
				m[i] = rnd_range(20);
		end else begin
			for (int i = 0; i < NE; i++)
				m[i] = ($urandom_range(0, 1) == 1) ? pick_extreme() : elem_t'($urandom());
		end
		return m;
	endfunction

	task automatic directed_matrices();
		mat_t m;
		send_matrix(one_eye(32'sd65536));
		send_matrix('0);
		send_matrix({NE{32'sh7fff_ffff}});
		send_matrix({NE{32'sh8000_0000}});
		send_matrix(one_eye(32'sd131072));
		send_matrix(one_eye(-32'sd32768));
		// tiny determinant: a nonzero exact value that rounds to zero
		send_matrix(one_eye(32'sd1));
		send_matrix(one_eye(32'sh7fff_ffff));
		send_matrix(one_eye(32'sh8000_0000));
		send_matrix({NE{32'sd65536}});
		send_matrix({NE{-32'sd1}});
		m = '0;
		m[1] = 32'sd65536;
		m[3] = 32'sd65536;
		m[8] = 32'sd65536;
		send_matrix(m);
		m = '{32'sd65536, 32'sd65536, 32'sd65536, 32'sd131072, 32'sd196608,
			32'sd65536, 32'sd65536, 32'sd0, 32'sd131072};
		send_matrix(m);
		m = one_eye(32'sd65536);
		m[1] = 32'sh7fff_ffff;
		m[5] = 32'sh8000_0000;
		send_matrix(m);
		m = one_eye(32'sd65536);
		m[0] = 32'sd65536 + 32'sd65;
		m[2] = -32'sd65;
		send_matrix(m);
		m = one_eye(32'sd65536);
		m[4] = 32'sd65536 - 32'sd66;
		send_matrix(m);
		m = random_matrix();
		for (int j = 0; j < 3; j++)
			m[3+j] = m[j];
		send_matrix(m);
		m = one_eye(32'sh8000_0000);
		m[4] = 32'sd1;
		send_matrix(m);
	endtask

	initial begin
		logic [15:0] tol_plan [5];
		tol_plan = '{16'd66, 16'd0, 16'd65535, 16'd1, 16'd300};
		tol_plan[4] = 16'($urandom_range(2, 65534));
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset tolerance first, then the directed matrices.
		directed_matrices();
		drain();

		foreach (tol_plan[p]) begin
			write_tolerance(tol_plan[p]);
			for (int n = 0; n < 366; n++) begin
				// every so often a stretch of back-to-back words
				if (n % 60 == 0)
					no_gaps = ($urandom_range(0, 2) == 0);
				send_matrix(random_matrix());
			end
			no_gaps = 1'b0;
			drain();
		end

		$display("%0d matrices sent, %0d result words checked (%0d singular, %0d identity)",
			sent, sb.words, sb.singulars, sb.identities);
		$display("tolerance phases: reset value, zero, full scale, one and a random value");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#20ms;
		$display("status: fail");
		$finish;
	end

endmodule
